// ===== rtl/core/uft_pkg.sv =====
// Shared types and constants for the union-find spanning tree block.
// Holds the forest size, field widths, opcodes and the parent store request.
// Depends on nothing; every other file imports it.
package uft_pkg;

	localparam int NODES = 64;
	localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int FIELD_W = 6;
	localparam int WEIGHT_W = 16;
	localparam int SUM_W = 22;
	localparam int CNT_W = 6;

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_EDGE = 1'b1;

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		logic rd_en;
		node_t rd_addr;
		logic wr_en;
		node_t wr_addr;
		node_t wr_data;
		logic clr;
	} pmem_req_t;

endpackage

// ===== rtl/core/uft_parent_store.sv =====
// Parent pointer store of the forest: one memory with a registered read port.
// Per-entry valid bits make an unwritten entry read as its own index.
// Depends on uft_pkg.
module uft_parent_store (
	input  logic              clk,
	input  logic              arst_n,
	input  uft_pkg::pmem_req_t req,
	output uft_pkg::node_t    parent
);
	import uft_pkg::*;

	node_t mem_q [NODES];
	logic [NODES-1:0] valid_q;
	node_t rdata_q;
	node_t raddr_q;
	logic rvld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.clr) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_q <= mem_q[req.rd_addr];
			rvld_q <= valid_q[req.rd_addr];
			raddr_q <= req.rd_addr;
		end
	end

	assign parent = rvld_q ? rdata_q : raddr_q;

endmodule

// ===== rtl/core/union_find_spanning_tree.sv =====
// Top level of the union-find spanning tree block: request sequencer and totals.
// Walks parent pointers through uft_parent_store; depends on uft_pkg.
//
// Channel   Handshake                 Fields
// request   start in, busy out        opcode, first_node, second_node, edge_weight
// result    done out (one cycle)      joined, first_root, second_root, tree_total,
//                                     accepted_count
//
// A clear, or an edge with a node out of range, finishes straight from idle. Each parent
// read of the single store port passes through the READ and CHECK states.
// The result strobe comes in the cycle after the last step, when busy is low again.
// Reset leaves every node its own root and both totals at zero, with no clearing pass.
// The receiver cannot stall, so results are never held back.
module union_find_spanning_tree (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [uft_pkg::FIELD_W-1:0]   first_node,
	input  logic [uft_pkg::FIELD_W-1:0]   second_node,
	input  logic [uft_pkg::WEIGHT_W-1:0]  edge_weight,
	output logic                          done,
	output logic                          joined,
	output logic [uft_pkg::FIELD_W-1:0]   first_root,
	output logic [uft_pkg::FIELD_W-1:0]   second_root,
	output logic [uft_pkg::SUM_W-1:0]     tree_total,
	output logic [uft_pkg::CNT_W-1:0]     accepted_count
);
	import uft_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_LINK
	} state_t;

	typedef enum logic {
		PASS_FIND,
		PASS_COMPRESS
	} pass_t;

	state_t state_q;
	pass_t pass_q;
	logic side_q;
	node_t a_q;
	node_t b_q;
	node_t addr_q;
	node_t ra_q;
	node_t rb_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic joined_q;
	node_t out_ra_q;
	node_t out_rb_q;

	pmem_req_t req;
	node_t parent;
	node_t root;
	node_t side_start;
	logic in_range;
	logic [SUM_W:0] sum_next;

	uft_parent_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.parent (parent)
	);

	assign root = side_q ? rb_q : ra_q;
	assign side_start = side_q ? b_q : a_q;
	assign in_range = (int'(first_node) < NODES) && (int'(second_node) < NODES);
	assign sum_next = {1'b0, sum_q} + (SUM_W + 1)'(w_q);

	always_comb begin
		req.rd_en = (state_q == ST_READ);
		req.rd_addr = addr_q;
		req.clr = (state_q == ST_IDLE) && start && (opcode == OP_CLEAR);
		req.wr_en = 1'b0;
		req.wr_addr = addr_q;
		req.wr_data = root;
		if (state_q == ST_CHECK && pass_q == PASS_COMPRESS) begin
			req.wr_en = 1'b1;
		end else if (state_q == ST_LINK && ra_q != rb_q) begin
			req.wr_en = 1'b1;
			req.wr_addr = ra_q;
			req.wr_data = rb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q <= PASS_FIND;
			side_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
			addr_q <= '0;
			ra_q <= '0;
			rb_q <= '0;
			w_q <= '0;
			sum_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
			joined_q <= 1'b0;
			out_ra_q <= '0;
			out_rb_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q <= NODE_W'(first_node);
						b_q <= NODE_W'(second_node);
						w_q <= edge_weight;
						addr_q <= NODE_W'(first_node);
						side_q <= 1'b0;
						pass_q <= PASS_FIND;
						if (opcode == OP_CLEAR) begin
							sum_q <= '0;
							cnt_q <= '0;
							done_q <= 1'b1;
							joined_q <= 1'b0;
							out_ra_q <= '0;
							out_rb_q <= '0;
						end else if (!in_range) begin
							done_q <= 1'b1;
							joined_q <= 1'b0;
							out_ra_q <= '0;
							out_rb_q <= '0;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (pass_q == PASS_FIND) begin
						if (parent == addr_q) begin
							if (side_q) begin
								rb_q <= addr_q;
							end else begin
								ra_q <= addr_q;
							end
							if (side_start == addr_q) begin
								if (side_q) begin
									state_q <= ST_LINK;
								end else begin
									side_q <= 1'b1;
									addr_q <= b_q;
									state_q <= ST_READ;
								end
							end else begin
								pass_q <= PASS_COMPRESS;
								addr_q <= side_start;
								state_q <= ST_READ;
							end
						end else begin
							addr_q <= parent;
							state_q <= ST_READ;
						end
					end else begin
						if (parent == root) begin
							pass_q <= PASS_FIND;
							if (side_q) begin
								state_q <= ST_LINK;
							end else begin
								side_q <= 1'b1;
								addr_q <= b_q;
								state_q <= ST_READ;
							end
						end else begin
							addr_q <= parent;
							state_q <= ST_READ;
						end
					end
				end
				ST_LINK: begin
					joined_q <= (ra_q != rb_q);
					out_ra_q <= ra_q;
					out_rb_q <= rb_q;
					if (ra_q != rb_q) begin
						sum_q <= sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
						if (cnt_q != CNT_MAX) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign joined = joined_q;
	assign first_root = FIELD_W'(out_ra_q);
	assign second_root = FIELD_W'(out_rb_q);
	assign tree_total = sum_q;
	assign accepted_count = cnt_q;

endmodule
